// File: hw/rtl/dif_pkg.sv
`timescale 1ns / 1ps

package dif_pkg;

  // Depth of the command queue between the parser and the fill engine.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_COL = 3'd0;
  localparam logic [2:0] REG_ORIGIN_ROW = 3'd1;
  localparam logic [2:0] REG_FILL_COLOR = 3'd2;
  localparam logic [2:0] REG_ROW_PITCH  = 3'd3;
  localparam logic [2:0] REG_FRAME_BASE = 3'd4;

  localparam logic [12:0] ROW_PITCH_RESET = 13'd320;

  typedef enum logic [2:0] {
    PH_CNT_LO,
    PH_CNT_HI,
    PH_X_LO,
    PH_X_HI,
    PH_Y_LO,
    PH_Y_HI,
    PH_CTRL,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    CMD_DONE,
    CMD_ORIGIN,
    CMD_RUN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        raw;
    logic [14:0] len;
    logic [15:0] row;
    logic [15:0] col;
  } cmd_t;

  typedef struct packed {
    logic [15:0] origin_col;
    logic [15:0] origin_row;
    logic [7:0]  fill_color;
    logic [12:0] row_pitch;
    logic [31:0] frame_base;
  } cfg_t;

endpackage

// File: hw/rtl/delta_image_solid_fill.sv
`timescale 1ns / 1ps
// A byte that causes a fill passes the command queue, stage A and the output register.
// Throughput: one byte per cycle while the queue is not full, the fill engine retiring
// one command per cycle through its multiply and pointer stages unless the output stalls.
// Reset (rst, synchronous): parser returns to the count low byte, the queue and the
// output empty, and the registers return to zero with row_pitch at 320.

module delta_image_solid_fill (
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // Fill commands.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] fill_address,
  output logic [14:0] fill_length,
  output logic [7:0]  fill_value,
  output logic        image_done,
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // The block is split into a parser front end and a fill back end joined by a
  // short command queue. The parser walks the record structure a byte at a time
  // and produces three kinds of commands: end of image, record origin and run.
  // The back end owns the write pointer, so the parser never waits on address
  // arithmetic; the multiply by the row pitch sits in its own stage.

  dif_pkg::cfg_t cfg;
  logic          in_accept;
  logic          front_cmd_valid;
  dif_pkg::cmd_t front_cmd;
  dif_pkg::cmd_t queue_cmd;
  logic          queue_not_empty;
  logic          queue_full;
  logic          queue_pop;

  // Registers can always be written; software must write them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_col <= 16'd0;
      cfg.origin_row <= 16'd0;
      cfg.fill_color <= 8'd0;
      cfg.row_pitch  <= dif_pkg::ROW_PITCH_RESET;
      cfg.frame_base <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dif_pkg::REG_ORIGIN_COL: cfg.origin_col <= cfg_data[15:0];
        dif_pkg::REG_ORIGIN_ROW: cfg.origin_row <= cfg_data[15:0];
        dif_pkg::REG_FILL_COLOR: cfg.fill_color <= cfg_data[7:0];
        dif_pkg::REG_ROW_PITCH:  cfg.row_pitch  <= cfg_data[12:0];
        dif_pkg::REG_FRAME_BASE: cfg.frame_base <= cfg_data;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // The input stalls only when the command queue is full. Every byte makes at
  // most one command, so a full queue is the only thing that can hold a beat.
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !in_stall;

  dif_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .cfg       (cfg),
    .cmd_valid (front_cmd_valid),
    .cmd       (front_cmd)
  );

  dif_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_cmd_valid),
    .wdata     (front_cmd),
    .pop       (queue_pop),
    .rdata     (queue_cmd),
    .not_empty (queue_not_empty),
    .full      (queue_full)
  );

  // The output register acts as the skid stage: the back end keeps pulling
  // commands while a finished fill waits to be taken, up to its one stage.
  dif_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (queue_not_empty),
    .cmd          (queue_cmd),
    .cmd_pop      (queue_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fill_address (fill_address),
    .fill_length  (fill_length),
    .fill_value   (fill_value),
    .image_done   (image_done)
  );

endmodule

// File: hw/rtl/dif_front.sv
`timescale 1ns / 1ps

// Record parser. Consumes one byte per accepted beat and emits at most one
// command per byte.
module dif_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  dif_pkg::cfg_t cfg,
  output logic          cmd_valid,
  output dif_pkg::cmd_t cmd
);

  dif_pkg::phase_t phase, phase_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic [14:0] record_pixels, record_pixels_next;
  logic        compressed_flag, compressed_flag_next;
  logic [15:0] record_column, record_column_next;
  logic [15:0] pixels_remaining, pixels_remaining_next;
  logic [14:0] bytes_to_skip, bytes_to_skip_next;

  logic [15:0] word;
  logic [6:0]  ctrl_len;
  logic [15:0] rem_after_ctrl;
  logic [14:0] ctrl_skip;
  logic [14:0] skip_dec;

  assign word           = {data_byte, held_low_byte};
  assign ctrl_len       = data_byte[7:1];
  assign rem_after_ctrl = pixels_remaining - {9'd0, ctrl_len};
  assign ctrl_skip      = data_byte[0] ? 15'd1 : {8'd0, ctrl_len};
  assign skip_dec       = (bytes_to_skip != 15'd0) ? bytes_to_skip - 15'd1 : 15'd0;

  function automatic logic positive(input logic [15:0] v);
    positive = (v != 16'd0) && !v[15];
  endfunction

  always_comb begin
    phase_next            = phase;
    held_low_byte_next    = held_low_byte;
    record_pixels_next    = record_pixels;
    compressed_flag_next  = compressed_flag;
    record_column_next    = record_column;
    pixels_remaining_next = pixels_remaining;
    bytes_to_skip_next    = bytes_to_skip;
    case (phase)
      dif_pkg::PH_CNT_LO: begin
        held_low_byte_next = data_byte;
        phase_next         = dif_pkg::PH_CNT_HI;
      end
      dif_pkg::PH_CNT_HI: begin
        if (word == 16'd0) begin
          phase_next = dif_pkg::PH_CNT_LO;
        end else begin
          record_pixels_next   = word[15:1];
          compressed_flag_next = word[0];
          phase_next           = dif_pkg::PH_X_LO;
        end
      end
      dif_pkg::PH_X_LO: begin
        held_low_byte_next = data_byte;
        phase_next         = dif_pkg::PH_X_HI;
      end
      dif_pkg::PH_X_HI: begin
        record_column_next = cfg.origin_col + word;
        phase_next         = dif_pkg::PH_Y_LO;
      end
      dif_pkg::PH_Y_LO: begin
        held_low_byte_next = data_byte;
        phase_next         = dif_pkg::PH_Y_HI;
      end
      dif_pkg::PH_Y_HI: begin
        if (compressed_flag) begin
          pixels_remaining_next = {1'b0, record_pixels};
          phase_next = (record_pixels != 15'd0) ? dif_pkg::PH_CTRL : dif_pkg::PH_CNT_LO;
        end else begin
          bytes_to_skip_next = record_pixels;
          phase_next         = dif_pkg::PH_SKIP;
        end
      end
      dif_pkg::PH_CTRL: begin
        pixels_remaining_next = rem_after_ctrl;
        bytes_to_skip_next    = ctrl_skip;
        if (ctrl_skip != 15'd0) begin
          phase_next = dif_pkg::PH_SKIP;
        end else begin
          phase_next = positive(rem_after_ctrl) ? dif_pkg::PH_CTRL : dif_pkg::PH_CNT_LO;
        end
      end
      dif_pkg::PH_SKIP: begin
        bytes_to_skip_next = skip_dec;
        if (skip_dec == 15'd0) begin
          phase_next = (compressed_flag && positive(pixels_remaining)) ?
                       dif_pkg::PH_CTRL : dif_pkg::PH_CNT_LO;
        end
      end
      default: begin
        phase_next = dif_pkg::PH_CNT_LO;
      end
    endcase
  end

  always_comb begin
    cmd_valid = 1'b0;
    cmd.kind  = dif_pkg::CMD_RUN;
    cmd.raw   = !compressed_flag;
    cmd.len   = {8'd0, ctrl_len};
    cmd.row   = cfg.origin_row + word;
    cmd.col   = record_column;
    case (phase)
      dif_pkg::PH_CNT_HI: begin
        cmd_valid = accept && (word == 16'd0);
        cmd.kind  = dif_pkg::CMD_DONE;
      end
      dif_pkg::PH_Y_HI: begin
        cmd_valid = accept;
        cmd.kind  = dif_pkg::CMD_ORIGIN;
        cmd.len   = record_pixels;
      end
      dif_pkg::PH_CTRL: begin
        cmd_valid = accept && (ctrl_len != 7'd0);
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= dif_pkg::PH_CNT_LO;
      held_low_byte    <= 8'd0;
      record_pixels    <= 15'd0;
      compressed_flag  <= 1'b0;
      record_column    <= 16'd0;
      pixels_remaining <= 16'd0;
      bytes_to_skip    <= 15'd0;
    end else if (accept) begin
      phase            <= phase_next;
      held_low_byte    <= held_low_byte_next;
      record_pixels    <= record_pixels_next;
      compressed_flag  <= compressed_flag_next;
      record_column    <= record_column_next;
      pixels_remaining <= pixels_remaining_next;
      bytes_to_skip    <= bytes_to_skip_next;
    end
  end

endmodule

// File: hw/rtl/dif_cmd_fifo.sv
`timescale 1ns / 1ps

// Small command queue between the parser and the fill engine.
module dif_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dif_pkg::cmd_t wdata,
  input  logic          pop,
  output dif_pkg::cmd_t rdata,
  output logic          not_empty,
  output logic          full
);

  dif_pkg::cmd_t                    mem [dif_pkg::CMD_DEPTH];
  logic [dif_pkg::CMD_PTR_W-1:0]    wptr;
  logic [dif_pkg::CMD_PTR_W-1:0]    rptr;
  logic [dif_pkg::CMD_CNT_W-1:0]    count;

  assign rdata     = mem[rptr];
  assign not_empty = (count != '0);
  assign full      = (count == dif_pkg::CMD_CNT_W'(dif_pkg::CMD_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + dif_pkg::CMD_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + dif_pkg::CMD_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + dif_pkg::CMD_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - dif_pkg::CMD_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("command queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + dif_pkg::CMD_CNT_W'(1))
    else $error("command queue count did not follow a write");

endmodule

// File: hw/rtl/dif_back.sv
`timescale 1ns / 1ps

// Fill engine. Stage A forms the row product, stage B tracks the write
// pointer and loads the output register.
module dif_back (
  input  logic          clk,
  input  logic          rst,
  input  dif_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  dif_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   fill_address,
  output logic [14:0]   fill_length,
  output logic [7:0]    fill_value,
  output logic          image_done
);

  logic          a_valid;
  dif_pkg::cmd_t a_cmd;
  logic [31:0]   a_prod;
  logic [31:0]   write_pointer;

  logic signed [29:0] row_mul;
  logic               b_adv;
  logic               b_emit;
  logic [31:0]        origin_ptr;

  assign row_mul    = $signed(cmd.row) * $signed({1'b0, cfg.row_pitch});
  assign b_adv      = a_valid && (!out_valid || !out_stall);
  assign cmd_pop    = cmd_valid && (!a_valid || b_adv);
  assign origin_ptr = cfg.frame_base + a_prod + {{16{a_cmd.col[15]}}, a_cmd.col};

  always_comb begin
    case (a_cmd.kind)
      dif_pkg::CMD_DONE:   b_emit = 1'b1;
      dif_pkg::CMD_ORIGIN: b_emit = a_cmd.raw;
      dif_pkg::CMD_RUN:    b_emit = 1'b1;
      default:             b_emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd_pop) begin
      a_valid <= 1'b1;
    end else if (b_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_cmd  <= cmd;
      a_prod <= {{2{row_mul[29]}}, row_mul};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= b_adv && b_emit;
      end
      if (b_adv) begin
        case (a_cmd.kind)
          dif_pkg::CMD_ORIGIN: write_pointer <= origin_ptr;
          dif_pkg::CMD_RUN:    write_pointer <= write_pointer + {17'd0, a_cmd.len};
          default:             write_pointer <= write_pointer;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      case (a_cmd.kind)
        dif_pkg::CMD_DONE: begin
          fill_address <= 32'd0;
          fill_length  <= 15'd0;
          fill_value   <= 8'd0;
          image_done   <= 1'b1;
        end
        dif_pkg::CMD_ORIGIN: begin
          fill_address <= origin_ptr;
          fill_length  <= a_cmd.len;
          fill_value   <= cfg.fill_color;
          image_done   <= 1'b0;
        end
        default: begin
          fill_address <= write_pointer;
          fill_length  <= a_cmd.len;
          fill_value   <= cfg.fill_color;
          image_done   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Checks the delta-image solid-fill decoder. Delta-image byte streams go in
// one beat at a time and fill commands come out. Both sides idle in short
// random bursts. A parser written here tracks every accepted byte and queues
// the fill command it must cause. Each output beat is compared against the
// oldest queued command.
module testbench;

  localparam int LONG_HOLD        = 150;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PHASES           = 7;
  localparam int RANDOM_PER_PHASE = 55;

  // One expected fill command, laid out like the output ports.
  typedef struct packed {
    logic [31:0] address;
    logic [14:0] length;
    logic [7:0]  value;
    logic        done;
  } fill_cmd_t;

  // One stream byte. Bytes from the directed script may carry the command
  // they cause, typed in by hand. That command is then used in place of the
  // parser's own.
  typedef struct packed {
    logic [7:0] data;
    logic       fixed;
    fill_cmd_t  fixed_fill;
  } stream_beat_t;

  localparam fill_cmd_t NO_FILL = '0;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] fill_address;
  logic [14:0] fill_length;
  logic [7:0]  fill_value;
  logic        image_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = dif_pkg::REG_ORIGIN_COL;
  logic [31:0] cfg_data  = 32'h0;

  delta_image_solid_fill dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fill_address (fill_address),
    .fill_length  (fill_length),
    .fill_value   (fill_value),
    .image_done   (image_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The directed script. It runs right after reset, so the origin is 0, the
  // color 0, the pitch 320 and the base 0. It holds an end of image, an empty
  // compressed record, and a raw record at the most extreme offsets. Last comes
  // a compressed record with a zero-length run, a run, a literal and an
  // overshooting run.
  localparam int SCRIPT_LEN = 29;
  stream_beat_t directed_script [SCRIPT_LEN] = '{
    '{8'h00, 1'b0, NO_FILL},
    '{8'h00, 1'b1, '{32'd0, 15'd0, 8'd0, 1'b1}},           // end of image
    '{8'h01, 1'b0, NO_FILL},                                // count 1: empty RLE record
    '{8'h00, 1'b0, NO_FILL},
    '{8'h00, 1'b0, NO_FILL},
    '{8'h00, 1'b0, NO_FILL},
    '{8'h00, 1'b0, NO_FILL},
    '{8'h00, 1'b0, NO_FILL},                                // no fill expected
    '{8'h02, 1'b0, NO_FILL},                                // raw, one pixel
    '{8'h00, 1'b0, NO_FILL},
    '{8'hFF, 1'b0, NO_FILL},
    '{8'h7F, 1'b0, NO_FILL},                                // x = 32767
    '{8'h00, 1'b0, NO_FILL},
    '{8'h80, 1'b1, '{32'hFF60_7FFF, 15'd1, 8'd0, 1'b0}},   // y = -32768
    '{8'hA5, 1'b0, NO_FILL},                                // the raw pixel, skipped
    '{8'h09, 1'b0, NO_FILL},                                // RLE, four pixels
    '{8'h00, 1'b0, NO_FILL},
    '{8'h05, 1'b0, NO_FILL},
    '{8'h00, 1'b0, NO_FILL},                                // x = 5
    '{8'h02, 1'b0, NO_FILL},
    '{8'h00, 1'b0, NO_FILL},                                // y = 2: pointer at 645
    '{8'h01, 1'b0, NO_FILL},                                // zero-length run
    '{8'h5A, 1'b0, NO_FILL},
    '{8'h05, 1'b1, '{32'd645, 15'd2, 8'd0, 1'b0}},         // run of two
    '{8'hC3, 1'b0, NO_FILL},
    '{8'h02, 1'b1, '{32'd647, 15'd1, 8'd0, 1'b0}},         // literal of one
    '{8'h7E, 1'b0, NO_FILL},
    '{8'hFF, 1'b1, '{32'd648, 15'd127, 8'd0, 1'b0}},       // run of 127 overshoots
    '{8'h3C, 1'b0, NO_FILL}
  };

  stream_beat_t stream_q [$];
  fill_cmd_t    expected_fills [$];
  int           mismatch_count = 0;
  bit           idle_on = 1'b1;
  bit           hold_request = 1'b0;

  // Register copies, updated as each write is accepted.
  logic [15:0] reg_x;
  logic [15:0] reg_y;
  logic [7:0]  reg_color;
  logic [12:0] reg_pitch;
  logic [31:0] reg_base;

  // Parser state.
  dif_pkg::phase_t parse_at;
  logic [7:0]  held_byte;
  logic [14:0] rec_pixels;
  logic        rec_rle;
  logic [15:0] rec_col;
  logic [15:0] px_left;
  logic [15:0] skip_left;
  logic [31:0] fill_ptr;

  function automatic void load_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      dif_pkg::REG_ORIGIN_COL: reg_x     = data[15:0];
      dif_pkg::REG_ORIGIN_ROW: reg_y     = data[15:0];
      dif_pkg::REG_FILL_COLOR: reg_color = data[7:0];
      dif_pkg::REG_ROW_PITCH:  reg_pitch = data[12:0];
      dif_pkg::REG_FRAME_BASE: reg_base  = data;
      default: ;
    endcase
  endfunction

  // The pixel count is a signed 16-bit value: a run longer than what is left
  // drives it negative and so ends the record.
  function automatic bit px_positive();
    return px_left != 16'd0 && !px_left[15];
  endfunction

  // Advances the parser by one stream byte. It reports whether the byte
  // causes a fill command, and which one.
  function automatic void advance_parser(input logic [7:0] b, output bit made,
                                         output fill_cmd_t f);
    logic [15:0] word;
    logic [15:0] sy;
    logic [6:0]  len;
    word = {b, held_byte};
    made = 1'b0;
    f = NO_FILL;
    case (parse_at)
      dif_pkg::PH_CNT_LO: begin
        held_byte = b;
        parse_at = dif_pkg::PH_CNT_HI;
      end
      dif_pkg::PH_CNT_HI: begin
        if (word == 16'd0) begin
          parse_at = dif_pkg::PH_CNT_LO;
          made = 1'b1;
          f.done = 1'b1;
        end else begin
          rec_pixels = word[15:1];
          rec_rle = word[0];
          parse_at = dif_pkg::PH_X_LO;
        end
      end
      dif_pkg::PH_X_LO: begin
        held_byte = b;
        parse_at = dif_pkg::PH_X_HI;
      end
      dif_pkg::PH_Y_LO: begin
        held_byte = b;
        parse_at = dif_pkg::PH_Y_HI;
      end
      dif_pkg::PH_X_HI: begin
        rec_col = reg_x + word;
        parse_at = dif_pkg::PH_Y_LO;
      end
      dif_pkg::PH_Y_HI: begin
        // Row and column are signed. Everything wraps at 32 bits.
        sy = reg_y + word;
        fill_ptr = reg_base + {{16{sy[15]}}, sy} * {19'd0, reg_pitch}
                   + {{16{rec_col[15]}}, rec_col};
        if (rec_rle) begin
          px_left = {1'b0, rec_pixels};
          parse_at = px_positive() ? dif_pkg::PH_CTRL : dif_pkg::PH_CNT_LO;
        end else begin
          skip_left = {1'b0, rec_pixels};
          parse_at = dif_pkg::PH_SKIP;
          made = 1'b1;
          f = '{fill_ptr, rec_pixels, reg_color, 1'b0};
        end
      end
      dif_pkg::PH_CTRL: begin
        len = b[7:1];
        made = (len != 7'd0);
        f = '{fill_ptr, {8'd0, len}, reg_color, 1'b0};
        fill_ptr = fill_ptr + {25'd0, len};
        px_left = px_left - {9'd0, len};
        skip_left = b[0] ? 16'd1 : {9'd0, len};
        if (skip_left != 16'd0) parse_at = dif_pkg::PH_SKIP;
        else parse_at = px_positive() ? dif_pkg::PH_CTRL : dif_pkg::PH_CNT_LO;
      end
      default: begin
        if (skip_left != 16'd0) skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0)
          parse_at = (rec_rle && px_positive()) ? dif_pkg::PH_CTRL : dif_pkg::PH_CNT_LO;
      end
    endcase
  endfunction

  function automatic void note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------
  // Stream building. Any byte string is a legal stream. The random records
  // follow the format, so that the parser gets past the header. Some records
  // carry fully random control bytes, which gives long literals and
  // overshooting runs.
  // ---------------------------------------------------------------------
  function automatic void queue_byte(logic [7:0] b);
    stream_q.push_back('{b, 1'b0, NO_FILL});
  endfunction

  function automatic void queue_word(logic [15:0] w);
    queue_byte(w[7:0]);
    queue_byte(w[15:8]);
  endfunction

  function automatic void queue_header(logic [15:0] count);
    queue_word(count);
    queue_word(16'($urandom));
    queue_word(16'($urandom));
  endfunction

  function automatic void queue_raw_record(int pixels);
    queue_header({15'(pixels), 1'b0});
    repeat (pixels) queue_byte(8'($urandom));
  endfunction

  function automatic void queue_rle_record(int pixels, int max_len, bit wild);
    int left;
    int len;
    logic [7:0] ctrl;
    queue_header({15'(pixels), 1'b1});
    left = pixels;
    while (left > 0) begin
      if (wild) begin
        ctrl = 8'($urandom);
      end else begin
        case ($urandom_range(0, 11))
          0: len = 0;
          1: len = (left < 127) ? $urandom_range(left, 127) : 127;
          default: len = $urandom_range(1, (left < max_len) ? left : max_len);
        endcase
        // Long spans go as runs so that the record stays short.
        ctrl = {7'(len), (len > 16) || ($urandom_range(0, 1) == 1)};
      end
      queue_byte(ctrl);
      if (ctrl[0]) queue_byte(8'($urandom));
      else repeat (ctrl[7:1]) queue_byte(8'($urandom));
      left -= ctrl[7:1];
    end
  endfunction

  function automatic void queue_random_record();
    case ($urandom_range(0, 9))
      0: queue_word(16'd0);
      1: queue_header(16'h0001);
      2, 3: queue_raw_record($urandom_range(1, 12));
      4: queue_rle_record($urandom_range(1, 300), 127, 1'b1);
      default: queue_rle_record($urandom_range(1, 40), 20, 1'b0);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Byte sender. The parser runs on each beat at the edge that accepts it.
  // A stalled byte is held. Otherwise the sender either offers the next
  // byte or idles for a burst of random length.
  // ---------------------------------------------------------------------
  stream_beat_t offered;
  int           gap_left = 0;
  bit           fill_made;
  fill_cmd_t    fill_seen;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_parser(offered.data, fill_made, fill_seen);
        if (offered.fixed) expected_fills.push_back(offered.fixed_fill);
        else if (fill_made) expected_fills.push_back(fill_seen);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0 && !(idle_on && $urandom_range(0, 5) == 0)) begin
          offered = stream_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= offered.data;
        end else begin
          in_valid <= 1'b0;
          if (stream_q.size() != 0) gap_left = $urandom_range(0, 2);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Fill receiver. It checks each accepted beat against the oldest
  // expectation, and then chooses its stall for the next cycle. A long hold
  // is counted here. It lets the command queue fill up, so that the input
  // has to stall.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  int hold_left  = 0;

  function automatic void check_fill();
    fill_cmd_t want;
    fill_cmd_t got;
    got = '{fill_address, fill_length, fill_value, image_done};
    if (expected_fills.size() == 0) begin
      note_error($sformatf("unexpected fill: addr %h len %0d value %h done %b",
                           got.address, got.length, got.value, got.done));
      return;
    end
    want = expected_fills.pop_front();
    if (got.address !== want.address || got.length !== want.length ||
        got.value !== want.value || got.done !== want.done)
      note_error($sformatf({"fill mismatch: expected addr %h len %0d value %h done %b, ",
                            "got addr %h len %0d value %h done %b"},
                           want.address, want.length, want.value, want.done,
                           got.address, got.length, got.value, got.done));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) check_fill();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // The watchdog counts cycles in which no beat moves on any channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing. The main flow waits on falling edges, so that queue and flag
  // updates never share a time step with the edge processes.
  // ---------------------------------------------------------------------
  task automatic write_register(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    load_register(idx, data);
    @(negedge clk);
  endtask

  // Waits until every byte has gone in and every fill has come out. Then it
  // keeps waiting, for a byte that causes no fill to settle.
  task automatic wait_idle();
    while (stream_q.size() != 0 || in_valid || expected_fills.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [31:0] noise;
    logic [15:0] x_val;
    logic [15:0] y_val;
    logic [7:0]  color_val;
    logic [12:0] pitch_val;
    logic [31:0] base_val;
    int          mark;

    reg_x = 16'd0;
    reg_y = 16'd0;
    reg_color = 8'd0;
    reg_pitch = dif_pkg::ROW_PITCH_RESET;
    reg_base = 32'd0;
    parse_at = dif_pkg::PH_CNT_LO;
    held_byte = 8'd0;
    rec_pixels = 15'd0;
    rec_rle = 1'b0;
    rec_col = 16'd0;
    px_left = 16'd0;
    skip_left = 16'd0;
    fill_ptr = 32'd0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_script[i]) stream_q.push_back(directed_script[i]);
    wait_idle();

    // Each phase starts from a complete image boundary, so that the registers
    // change only while the parser waits for a new count word. The first
    // two phases use the register extremes. The next two take the pitch out of range,
    // and from the third on stray upper bits go above each register under 32 bits.
    for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
      noise = (phase_no >= 2) ? $urandom : 32'd0;
      x_val = 16'($urandom);
      y_val = 16'($urandom);
      color_val = 8'($urandom);
      base_val = $urandom;
      pitch_val = 13'($urandom_range(1, 4096));
      case (phase_no)
        0: begin
          x_val = 16'h7FFF;
          y_val = 16'h7FFF;
          color_val = 8'hFF;
          pitch_val = 13'd4096;
          base_val = 32'hFFFF_FFFF;
        end
        1: begin
          x_val = 16'h8000;
          y_val = 16'h8000;
          color_val = 8'h00;
          pitch_val = 13'd1;
          base_val = 32'h0;
        end
        2: pitch_val = 13'd0;
        3: pitch_val = 13'h1FFF;
        default: ;
      endcase
      write_register(dif_pkg::REG_ORIGIN_COL, {noise[31:16], x_val});
      write_register(dif_pkg::REG_ORIGIN_ROW, {noise[31:16], y_val});
      write_register(dif_pkg::REG_FILL_COLOR, {noise[31:8], color_val});
      write_register(dif_pkg::REG_ROW_PITCH, {noise[31:13], pitch_val});
      write_register(dif_pkg::REG_FRAME_BASE, base_val);

      // The last phase runs with no idling on either side.
      idle_on = (phase_no < PHASES - 1);

      // During the long hold, a string of end markers makes a fill for every
      // second byte, enough to fill the command path and stall the input.
      if (phase_no == 1) repeat (8) queue_word(16'd0);

      mark = stream_q.size();
      while (stream_q.size() - mark < RANDOM_PER_PHASE) queue_random_record();
      queue_word(16'd0);

      if (phase_no == 1) hold_request = 1'b1;
      wait_idle();
    end

    // A raw record with the largest count closes the run. Its fill comes out
    // with the header, and the stream stops inside its body.
    queue_header({15'h7FFF, 1'b0});
    wait_idle();

    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dif_pkg.sv
hw/rtl/dif_front.sv
hw/rtl/dif_cmd_fifo.sv
hw/rtl/dif_back.sv
hw/rtl/delta_image_solid_fill.sv
sim/testbench.sv
